>>> sv/mie_pkg.sv
package mie_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KMUL,
    ST_KADD,
    ST_INIT,
    ST_SKMUL,
    ST_BASE,
    ST_POW,
    ST_ACC,
    ST_NEXT,
    ST_SISSUE,
    ST_SADD,
    ST_SCALE,
    ST_DONE
  } state_t;

  localparam logic CFG_CONTRIBUTORS = 1'b0;
  localparam logic CFG_METHOD       = 1'b1;

  localparam logic [63:0] CLAMP_THRESH = 64'd4299262264;
  localparam logic [40:0] TERM_CAP     = 41'h100_0000_0000;
  localparam logic [40:0] ONE_Q32      = 41'h001_0000_0000;
  localparam logic [16:0] OUT_ONE      = 17'h1_0000;
  localparam logic [63:0] ACC_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

>>> sv/mixture_inclusion_exclusion_prob.sv
// an unknown allele is taken in idle, a known allele also passes KMUL and KADD, last or not
// a last item then takes a power with e = 2x or x for each of 2^u subsets, u unknown alleles
// each power step runs on one shared 32x32 multiplier (four partial products)
// throughput: one item at a time, the input is not ready until the result is registered
// reset: synchronous active low, clears the sequencer and mixture state,
// contributors returns to 1 and method to 0
module mixture_inclusion_exclusion_prob #(
  parameter int MAX_ALLELES    = 12,
  parameter int FREQ_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [16:0] in_frequency,
  input  logic        in_is_unknown,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_probability,
  output logic        out_clamped,
  output logic        out_too_many
);

  localparam int FW  = FREQ_FRAC_BITS + 1;
  localparam int XW  = (FW > 17) ? FW : 17;
  localparam int SW  = FREQ_FRAC_BITS + 5;
  localparam int PW  = 2 * FREQ_FRAC_BITS + 8;
  localparam int CW  = $clog2(MAX_ALLELES + 1);
  localparam int IW  = (MAX_ALLELES > 1) ? $clog2(MAX_ALLELES) : 1;
  localparam int KW  = MAX_ALLELES + 1;
  localparam int PDN = (2 * FREQ_FRAC_BITS > 32) ? 2 * FREQ_FRAC_BITS - 32 : 0;
  localparam int PUP = (2 * FREQ_FRAC_BITS < 32) ? 32 - 2 * FREQ_FRAC_BITS : 0;
  localparam int BSH = 32 - FREQ_FRAC_BITS;

  mie_pkg::state_t state_r, state_nxt;

  logic [3:0]  contributors_r;
  logic        method_r;

  logic [FW-1:0] store_r [MAX_ALLELES];
  logic [CW-1:0] ucnt_r, acnt_r;
  logic [SW-1:0] kt_r, s_r;
  logic [PW-1:0] kpt_r, p_r;
  logic          ovf_r, last_r, add_r;
  logic [FW-1:0] f_r;
  logic [MAX_ALLELES-1:0] g_r;
  logic [KW-1:0] k_r;
  logic [IW-1:0] idx;
  logic [KW-1:0] kp1;
  logic signed [63:0] acc_r;
  logic [40:0] base_r, r_r;
  logic [4:0]  e_r, cnt_r;
  logic [2:0]  ph_r;
  logic [63:0] mac_r, prod_r;
  logic [31:0] mop_a, mop_b;
  logic [63:0] mac_fin;
  logic [63:0] ptot, base_full;
  logic [SW-1:0] s_rem;
  logic [XW-1:0] freq_ext;
  logic [FW-1:0] fsat;
  logic          fire, counted;
  logic [63:0]   acc_u, lim;
  logic [16:0]   prob;
  logic          clamp;

  assign fire     = in_valid && in_ready;
  assign in_ready = (state_r == mie_pkg::ST_IDLE);
  assign counted  = (acnt_r < CW'(MAX_ALLELES));
  assign freq_ext = XW'(in_frequency);
  assign fsat     = (freq_ext > (XW'(1) << FREQ_FRAC_BITS)) ? (FW'(1) << FREQ_FRAC_BITS)
                                                            : FW'(freq_ext);
  assign kp1      = k_r + KW'(1);
  assign s_rem    = s_r - SW'(f_r);
  assign mac_fin  = mac_r + (prod_r << 32);
  assign ptot     = 64'(p_r) + 64'(kpt_r) + prod_r;
  assign base_full = (64'(s_r + kt_r) << BSH)
                   + (method_r ? ((ptot >> PDN) << PUP) : 64'd0);
  assign acc_u    = acc_r;
  assign lim      = mie_pkg::ACC_MAX >> contributors_r;

  always_comb begin
    idx = '0;
    for (int i = MAX_ALLELES - 1; i >= 0; i--) begin
      if (kp1[i]) idx = IW'(i);
    end
  end

  always_comb begin
    mop_a = '0;
    mop_b = '0;
    case (state_r)
      mie_pkg::ST_KMUL: begin
        mop_a = 32'(f_r);
        mop_b = 32'(kt_r);
      end
      mie_pkg::ST_SKMUL: begin
        mop_a = 32'(s_r);
        mop_b = 32'(kt_r);
      end
      mie_pkg::ST_SISSUE: begin
        mop_a = 32'(f_r);
        mop_b = add_r ? 32'(s_r) : 32'(s_rem);
      end
      mie_pkg::ST_POW: begin
        mop_a = ph_r[1] ? 32'(r_r[40:32]) : r_r[31:0];
        mop_b = ph_r[0] ? 32'(base_r[40:32]) : base_r[31:0];
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
  end

  always_comb begin
    if (acc_r < 0) begin
      prob  = '0;
      clamp = 1'b1;
    end else if (acc_u >= mie_pkg::CLAMP_THRESH) begin
      prob  = mie_pkg::OUT_ONE;
      clamp = 1'b1;
    end else begin
      prob  = (acc_u[63:16] > 48'(mie_pkg::OUT_ONE)) ? mie_pkg::OUT_ONE : acc_u[32:16];
      clamp = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mie_pkg::ST_IDLE: begin
        if (fire) begin
          if (counted && !in_is_unknown) state_nxt = mie_pkg::ST_KMUL;
          else if (in_last)              state_nxt = mie_pkg::ST_INIT;
        end
      end
      mie_pkg::ST_KMUL:   state_nxt = mie_pkg::ST_KADD;
      mie_pkg::ST_KADD:   state_nxt = last_r ? mie_pkg::ST_INIT : mie_pkg::ST_IDLE;
      mie_pkg::ST_INIT:   state_nxt = mie_pkg::ST_SKMUL;
      mie_pkg::ST_SKMUL:  state_nxt = mie_pkg::ST_BASE;
      mie_pkg::ST_BASE:   state_nxt = (e_r == 5'd0) ? mie_pkg::ST_ACC : mie_pkg::ST_POW;
      mie_pkg::ST_POW: begin
        if (ph_r == 3'd4 && cnt_r + 5'd1 == e_r) state_nxt = mie_pkg::ST_ACC;
      end
      mie_pkg::ST_ACC: begin
        state_nxt = (kp1 == (KW'(1) << ucnt_r)) ? mie_pkg::ST_SCALE : mie_pkg::ST_NEXT;
      end
      mie_pkg::ST_NEXT:   state_nxt = mie_pkg::ST_SISSUE;
      mie_pkg::ST_SISSUE: state_nxt = mie_pkg::ST_SADD;
      mie_pkg::ST_SADD:   state_nxt = mie_pkg::ST_SKMUL;
      mie_pkg::ST_SCALE:  state_nxt = mie_pkg::ST_DONE;
      mie_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_nxt = mie_pkg::ST_IDLE;
      end
      default: state_nxt = mie_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mie_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contributors_r <= 4'd1;
      method_r       <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == mie_pkg::CFG_CONTRIBUTORS) contributors_r <= cfg_wdata;
      else                                        method_r       <= cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && counted && in_is_unknown) store_r[ucnt_r[IW-1:0]] <= fsat;
  end

  always_ff @(posedge clk) begin
    prod_r <= mop_a * mop_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ucnt_r    <= '0;
      acnt_r    <= '0;
      kt_r      <= '0;
      kpt_r     <= '0;
      ovf_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state_r != mie_pkg::ST_DONE) out_valid <= 1'b0;
      case (state_r)
        mie_pkg::ST_IDLE: begin
          if (fire) begin
            f_r    <= fsat;
            last_r <= in_last;
            if (counted) begin
              acnt_r <= acnt_r + CW'(1);
              if (in_is_unknown) ucnt_r <= ucnt_r + CW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        mie_pkg::ST_KADD: begin
          kpt_r <= kpt_r + PW'(prod_r);
          kt_r  <= kt_r + SW'(f_r);
        end
        mie_pkg::ST_INIT: begin
          s_r   <= '0;
          p_r   <= '0;
          g_r   <= '0;
          k_r   <= '0;
          acc_r <= '0;
          e_r   <= method_r ? {1'b0, contributors_r} : {contributors_r, 1'b0};
        end
        mie_pkg::ST_BASE: begin
          base_r <= (base_full > 64'(mie_pkg::TERM_CAP)) ? mie_pkg::TERM_CAP
                                                         : base_full[40:0];
          r_r    <= mie_pkg::ONE_Q32;
          cnt_r  <= '0;
          ph_r   <= '0;
          mac_r  <= '0;
        end
        mie_pkg::ST_POW: begin
          case (ph_r)
            3'd1:    mac_r <= prod_r >> 32;
            3'd2:    mac_r <= mac_r + prod_r;
            3'd3:    mac_r <= mac_r + prod_r;
            default: mac_r <= mac_r;
          endcase
          if (ph_r == 3'd4) begin
            r_r   <= (mac_fin > 64'(mie_pkg::TERM_CAP)) ? mie_pkg::TERM_CAP : mac_fin[40:0];
            cnt_r <= cnt_r + 5'd1;
            ph_r  <= '0;
          end else begin
            ph_r <= ph_r + 3'd1;
          end
        end
        mie_pkg::ST_ACC: begin
          if ((ucnt_r[0] ^ k_r[0]) != 1'b0) acc_r <= acc_r - $signed(64'(r_r));
          else                              acc_r <= acc_r + $signed(64'(r_r));
        end
        mie_pkg::ST_NEXT: begin
          f_r   <= store_r[idx];
          add_r <= ~g_r[idx];
          g_r   <= g_r ^ (MAX_ALLELES'(1) << idx);
          k_r   <= kp1;
        end
        mie_pkg::ST_SADD: begin
          if (add_r) begin
            p_r <= p_r + PW'(prod_r);
            s_r <= s_r + SW'(f_r);
          end else begin
            p_r <= p_r - PW'(prod_r);
            s_r <= s_rem;
          end
        end
        mie_pkg::ST_SCALE: begin
          if (method_r && acc_r > 0) begin
            if (acc_u > lim) acc_r <= $signed(mie_pkg::ACC_MAX);
            else             acc_r <= acc_r <<< contributors_r;
          end
        end
        mie_pkg::ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            out_probability <= prob;
            out_clamped     <= clamp;
            out_too_many    <= ovf_r;
            ucnt_r          <= '0;
            acnt_r          <= '0;
            kt_r            <= '0;
            kpt_r           <= '0;
            ovf_r           <= 1'b0;
          end
        end
        default: begin
          ovf_r <= ovf_r;
        end
      endcase
    end
  end

endmodule
